### design/tgaspd_pkg.sv
// ----------------------------------------------------------------------------
// tgaspd_pkg
// Shared types and codes for the streaming TGA pixel decoder.
// ----------------------------------------------------------------------------
package tgaspd_pkg;

   localparam int BYTE_W   = 8;
   localparam int DIM_W    = 16;
   localparam int RUN_W    = 8;
   localparam int KIND_W   = 2;

   typedef enum logic [KIND_W-1:0] {
      KIND_ACCEPT = 2'd0,
      KIND_REJECT = 2'd1,
      KIND_RUN    = 2'd2
   } kind_type;

   // one input byte of the file
   typedef struct packed {
      logic [BYTE_W-1:0] data_byte;
      logic              first_byte;
   } in_item_type;

   // one result item
   typedef struct packed {
      kind_type          kind;
      logic [DIM_W-1:0]  image_width;
      logic [DIM_W-1:0]  image_height;
      logic [BYTE_W-1:0] red;
      logic [BYTE_W-1:0] green;
      logic [BYTE_W-1:0] blue;
      logic [BYTE_W-1:0] alpha;
      logic [RUN_W-1:0]  run_length;
      logic              last;
   } result_type;

endpackage

### design/tga_stream_pixel_decoder.sv
// path: the byte is registered, then any result loads the rsp_valid register
// throughput: one byte per cycle, no bubbles while the result side keeps up
// the rate is set by the parser step between the input and result registers
// reset: synchronous, clears the registers' valid flags and the parse state;
// the decoder then waits for a byte marked first_byte
// ----------------------------------------------------------------------------
// tga_stream_pixel_decoder
// Streaming TGA decoder: header, id skip, raw and RLE pixel runs in RGBA.
// ----------------------------------------------------------------------------
module tga_stream_pixel_decoder (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [tgaspd_pkg::BYTE_W-1:0]      req_data_byte,
   input  logic                               req_first_byte,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [tgaspd_pkg::KIND_W-1:0]      rsp_kind,
   output logic [tgaspd_pkg::DIM_W-1:0]       rsp_image_width,
   output logic [tgaspd_pkg::DIM_W-1:0]       rsp_image_height,
   output logic [tgaspd_pkg::BYTE_W-1:0]      rsp_red,
   output logic [tgaspd_pkg::BYTE_W-1:0]      rsp_green,
   output logic [tgaspd_pkg::BYTE_W-1:0]      rsp_blue,
   output logic [tgaspd_pkg::BYTE_W-1:0]      rsp_alpha,
   output logic [tgaspd_pkg::RUN_W-1:0]       rsp_run_length,
   output logic                               rsp_last
);
   import tgaspd_pkg::*;

   in_item_type req_item, item;
   logic        item_valid, step, can_take, res_valid;
   result_type  res, rsp_res;

   assign req_item.data_byte  = req_data_byte;
   assign req_item.first_byte = req_first_byte;

   // parser advances only when the result register can take its output
   assign step = item_valid && can_take;

   tgaspd_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_item   (req_item),
      .pop        (step),
      .item_valid (item_valid),
      .item       (item)
   );

   tgaspd_parser u_parser (
      .clock     (clock),
      .reset     (reset),
      .step      (step),
      .item      (item),
      .res_valid (res_valid),
      .res       (res)
   );

   tgaspd_out_reg u_out_reg (
      .clock      (clock),
      .reset      (reset),
      .load       (step),
      .load_valid (res_valid),
      .load_res   (res),
      .can_take   (can_take),
      .rsp_valid  (rsp_valid),
      .rsp_ready  (rsp_ready),
      .rsp_res    (rsp_res)
   );

   assign rsp_kind         = rsp_res.kind;
   assign rsp_image_width  = rsp_res.image_width;
   assign rsp_image_height = rsp_res.image_height;
   assign rsp_red          = rsp_res.red;
   assign rsp_green        = rsp_res.green;
   assign rsp_blue         = rsp_res.blue;
   assign rsp_alpha        = rsp_res.alpha;
   assign rsp_run_length   = rsp_res.run_length;
   assign rsp_last         = rsp_res.last;

endmodule

### design/tgaspd_in_reg.sv
// ----------------------------------------------------------------------------
// tgaspd_in_reg
// Input register: holds one byte transfer until the parser consumes it.
// ----------------------------------------------------------------------------
module tgaspd_in_reg (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  tgaspd_pkg::in_item_type   req_item,
   input  logic                      pop,
   output logic                      item_valid,
   output tgaspd_pkg::in_item_type   item
);
   import tgaspd_pkg::*;

   logic        full_ff, full_in;
   in_item_type item_ff;

   assign req_ready  = !full_ff || pop;
   assign item_valid = full_ff;
   assign item       = item_ff;

   always_comb begin
      full_in = full_ff;
      if (req_valid && req_ready) begin
         full_in = 1'b1;
      end else if (pop) begin
         full_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         full_ff <= 1'b0;
      end else begin
         full_ff <= full_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         item_ff <= req_item;
      end
   end

endmodule

### design/tgaspd_parser.sv
// ----------------------------------------------------------------------------
// tgaspd_parser
// Header parse, id skip and RLE / raw pixel decode, one byte per step.
// ----------------------------------------------------------------------------
module tgaspd_parser (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    step,
   input  tgaspd_pkg::in_item_type item,
   output logic                    res_valid,
   output tgaspd_pkg::result_type  res
);
   import tgaspd_pkg::*;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'd0,
      PH_HEADER = 3'd1,
      PH_IDSKIP = 3'd2,
      PH_HEAD   = 3'd3,
      PH_PIXEL  = 3'd4,
      PH_DONE   = 3'd5
   } phase_type;

   localparam logic [4:0] HDR_LAST = 5'd17;
   localparam logic [7:0] TYPE_RGB      = 8'd2;
   localparam logic [7:0] TYPE_GRAY     = 8'd3;
   localparam logic [7:0] TYPE_RGB_RLE  = 8'd10;
   localparam logic [7:0] TYPE_GRAY_RLE = 8'd11;
   localparam logic [7:0] BPP_32 = 8'd32;
   localparam logic [7:0] BPP_24 = 8'd24;
   localparam logic [7:0] BPP_8  = 8'd8;
   localparam logic [7:0] OPAQUE = 8'd255;

   phase_type   phase_ff, phase_in;
   logic [4:0]  hdr_idx_ff, hdr_idx_in;
   logic [7:0]  id_skip_ff, id_skip_in;
   logic [7:0]  map_type_ff, map_type_in;
   logic [7:0]  img_type_ff, img_type_in;
   logic [7:0]  bpp_ff, bpp_in;
   logic [15:0] width_ff, width_in;
   logic [15:0] height_ff, height_in;
   logic [31:0] pix_left_ff, pix_left_in;
   logic [7:0]  pkt_left_ff, pkt_left_in;
   logic        pkt_run_ff, pkt_run_in;
   logic [1:0]  col_idx_ff, col_idx_in;
   logic [23:0] col_bytes_ff, col_bytes_in;

   logic        is_gray, is_rle, type_ok, bpp_ok, four_bytes;
   phase_type   data_phase;
   logic [4:0]  idx;
   logic [31:0] pix_product;
   logic [23:0] col_new;
   logic [7:0]  px_r, px_g, px_b, px_a;
   logic [7:0]  run;
   logic [7:0]  pkt_after;
   logic [31:0] pix_after;
   logic        have_pixel;

   assign is_gray    = (img_type_ff == TYPE_GRAY) || (img_type_ff == TYPE_GRAY_RLE);
   assign is_rle     = (img_type_ff == TYPE_RGB_RLE) || (img_type_ff == TYPE_GRAY_RLE);
   assign type_ok    = (img_type_ff == TYPE_RGB) || (img_type_ff == TYPE_GRAY) ||
                       (img_type_ff == TYPE_RGB_RLE) || (img_type_ff == TYPE_GRAY_RLE);
   assign bpp_ok     = (bpp_ff == BPP_32) || (bpp_ff == BPP_24) || (bpp_ff == BPP_8);
   assign four_bytes = (bpp_ff == BPP_32);
   assign data_phase = is_rle ? PH_HEAD : PH_PIXEL;
   assign idx        = item.first_byte ? 5'd0 : hdr_idx_ff;
   assign pix_product = width_ff * height_ff;

   // color assembly: place the byte first, then read B,G,R out of the new word
   always_comb begin
      col_new = col_bytes_ff;
      unique case (col_idx_ff)
         2'd0:    col_new[7:0]   = item.data_byte;
         2'd1:    col_new[15:8]  = item.data_byte;
         2'd2:    col_new[23:16] = item.data_byte;
         default: col_new        = col_bytes_ff;
      endcase
   end

   always_comb begin
      if (is_gray) begin
         have_pixel = 1'b1;
         px_r = item.data_byte;
         px_g = item.data_byte;
         px_b = item.data_byte;
         px_a = OPAQUE;
      end else begin
         have_pixel = four_bytes ? (col_idx_ff == 2'd3) : (col_idx_ff == 2'd2);
         px_b = col_new[7:0];
         px_g = col_new[15:8];
         px_r = col_new[23:16];
         px_a = four_bytes ? item.data_byte : OPAQUE;
      end
   end

   // run clamped to the pixels still owed
   always_comb begin
      run       = 8'd1;
      pkt_after = pkt_left_ff;
      if (is_rle && pkt_run_ff) begin
         run       = (pix_left_ff < {24'd0, pkt_left_ff}) ? pix_left_ff[7:0] : pkt_left_ff;
         pkt_after = 8'd0;
      end else if (is_rle) begin
         pkt_after = pkt_left_ff - 8'd1;
      end
      pix_after = pix_left_ff - {24'd0, run};
   end

   always_comb begin
      phase_in     = phase_ff;
      hdr_idx_in   = hdr_idx_ff;
      id_skip_in   = id_skip_ff;
      map_type_in  = map_type_ff;
      img_type_in  = img_type_ff;
      bpp_in       = bpp_ff;
      width_in     = width_ff;
      height_in    = height_ff;
      pix_left_in  = pix_left_ff;
      pkt_left_in  = pkt_left_ff;
      pkt_run_in   = pkt_run_ff;
      col_idx_in   = col_idx_ff;
      col_bytes_in = col_bytes_ff;
      res_valid    = 1'b0;
      res          = '0;
      res.kind     = KIND_ACCEPT;

      if (item.first_byte || phase_ff == PH_HEADER) begin
         phase_in   = PH_HEADER;
         hdr_idx_in = idx + 5'd1;
         unique case (idx)
            5'd0:    id_skip_in  = item.data_byte;
            5'd1:    map_type_in = item.data_byte;
            5'd2:    img_type_in = item.data_byte;
            5'd12:   width_in    = {width_ff[15:8], item.data_byte};
            5'd13:   width_in    = {item.data_byte, width_ff[7:0]};
            5'd14:   height_in   = {height_ff[15:8], item.data_byte};
            5'd15:   height_in   = {item.data_byte, height_ff[7:0]};
            5'd16:   bpp_in      = item.data_byte;
            default: ;
         endcase
         if (idx == HDR_LAST) begin
            res_valid        = 1'b1;
            res.image_width  = width_ff;
            res.image_height = height_ff;
            if (!type_ok || !bpp_ok || map_type_ff != 8'd0) begin
               phase_in = PH_DONE;
               res.kind = KIND_REJECT;
               res.last = 1'b1;
            end else begin
               pix_left_in  = pix_product;
               pkt_left_in  = 8'd0;
               pkt_run_in   = 1'b0;
               col_idx_in   = 2'd0;
               col_bytes_in = 24'd0;
               if (width_ff == 16'd0 || height_ff == 16'd0) begin
                  phase_in = PH_DONE;
                  res.last = 1'b1;
               end else begin
                  phase_in = (id_skip_ff != 8'd0) ? PH_IDSKIP : data_phase;
               end
            end
         end
      end else begin
         unique case (phase_ff)
            PH_IDSKIP: begin
               id_skip_in = id_skip_ff - 8'd1;
               if (id_skip_ff == 8'd1) begin
                  phase_in = data_phase;
               end
            end
            PH_HEAD: begin
               pkt_run_in   = item.data_byte[7];
               pkt_left_in  = item.data_byte[7] ? (item.data_byte - 8'd127)
                                                : (item.data_byte + 8'd1);
               col_idx_in   = 2'd0;
               col_bytes_in = 24'd0;
               phase_in     = PH_PIXEL;
            end
            PH_PIXEL: begin
               if (!is_gray && !have_pixel) begin
                  col_idx_in   = col_idx_ff + 2'd1;
                  col_bytes_in = col_new;
               end else begin
                  if (!is_gray) begin
                     col_idx_in   = 2'd0;
                     col_bytes_in = 24'd0;
                  end
                  res_valid      = 1'b1;
                  res.kind       = KIND_RUN;
                  res.red        = px_r;
                  res.green      = px_g;
                  res.blue       = px_b;
                  res.alpha      = px_a;
                  res.run_length = run;
                  pkt_left_in    = pkt_after;
                  pix_left_in    = pix_after;
                  if (pix_after == 32'd0) begin
                     res.last = 1'b1;
                     phase_in = PH_DONE;
                  end else if (is_rle && pkt_after == 8'd0) begin
                     phase_in = PH_HEAD;
                  end else begin
                     phase_in = PH_PIXEL;
                  end
               end
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         hdr_idx_ff   <= 5'd0;
         id_skip_ff   <= 8'd0;
         map_type_ff  <= 8'd0;
         img_type_ff  <= 8'd0;
         bpp_ff       <= 8'd0;
         width_ff     <= 16'd0;
         height_ff    <= 16'd0;
         pix_left_ff  <= 32'd0;
         pkt_left_ff  <= 8'd0;
         pkt_run_ff   <= 1'b0;
         col_idx_ff   <= 2'd0;
         col_bytes_ff <= 24'd0;
      end else if (step) begin
         phase_ff     <= phase_in;
         hdr_idx_ff   <= hdr_idx_in;
         id_skip_ff   <= id_skip_in;
         map_type_ff  <= map_type_in;
         img_type_ff  <= img_type_in;
         bpp_ff       <= bpp_in;
         width_ff     <= width_in;
         height_ff    <= height_in;
         pix_left_ff  <= pix_left_in;
         pkt_left_ff  <= pkt_left_in;
         pkt_run_ff   <= pkt_run_in;
         col_idx_ff   <= col_idx_in;
         col_bytes_ff <= col_bytes_in;
      end
   end

endmodule

### design/tgaspd_out_reg.sv
// ----------------------------------------------------------------------------
// tgaspd_out_reg
// Result register: holds one result until the consumer takes the transfer.
// ----------------------------------------------------------------------------
module tgaspd_out_reg (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   load,
   input  logic                   load_valid,
   input  tgaspd_pkg::result_type load_res,
   output logic                   can_take,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output tgaspd_pkg::result_type rsp_res
);
   import tgaspd_pkg::*;

   logic       valid_ff, valid_in;
   result_type res_ff;

   assign can_take  = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_res   = res_ff;

   always_comb begin
      valid_in = valid_ff;
      if (can_take) begin
         valid_in = load && load_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (can_take && load && load_valid) begin
         res_ff <= load_res;
      end
   end

endmodule

### design/tgaspd_checker.sv
// ----------------------------------------------------------------------------
// tgaspd_checker
// Port-level checks on the decoder's result stream.
// ----------------------------------------------------------------------------
module tgaspd_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_ready,
   input logic [tgaspd_pkg::KIND_W-1:0]      rsp_kind,
   input logic [tgaspd_pkg::DIM_W-1:0]       rsp_image_width,
   input logic [tgaspd_pkg::DIM_W-1:0]       rsp_image_height,
   input logic [tgaspd_pkg::BYTE_W-1:0]      rsp_red,
   input logic [tgaspd_pkg::BYTE_W-1:0]      rsp_green,
   input logic [tgaspd_pkg::BYTE_W-1:0]      rsp_blue,
   input logic [tgaspd_pkg::BYTE_W-1:0]      rsp_alpha,
   input logic [tgaspd_pkg::RUN_W-1:0]       rsp_run_length,
   input logic                               rsp_last
);
   import tgaspd_pkg::*;

   // no result right after reset
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // a stalled result keeps its kind, run length, last flag and red byte
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_kind) &&
      $stable(rsp_run_length) && $stable(rsp_last) && $stable(rsp_red))
      else $error("stalled result changed");

   // header results carry dimensions only
   a_header_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind != KIND_RUN |-> rsp_run_length == 8'd0 &&
      rsp_red == 8'd0 && rsp_green == 8'd0 && rsp_blue == 8'd0 && rsp_alpha == 8'd0)
      else $error("header result carries pixel data");

   // pixel runs cover 1..128 pixels and carry no dimensions
   a_run_fields: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_RUN |-> rsp_run_length != 8'd0 &&
      rsp_run_length <= 8'd128 && rsp_image_width == 16'd0 && rsp_image_height == 16'd0)
      else $error("bad pixel run fields");

   // a rejection always closes the file
   a_reject_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_REJECT |-> rsp_last)
      else $error("rejection without last");

endmodule

bind tga_stream_pixel_decoder tgaspd_checker u_checker (.*);

### tb/tga_stream_pixel_decoder_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tga_stream_pixel_decoder_test
// Streams TGA files byte by byte into the decoder and checks every header
// and pixel run result against a cycle-free decoder kept in the bench.
// Directed files cover header checks, raw and RLE data, id skipping,
// restarts and trailing bytes; random files follow under three idle mixes.
// ----------------------------------------------------------------------------
module tga_stream_pixel_decoder_test;
   import tgaspd_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 8;
   localparam int WHOLE_FILE   = 32'h7fff_ffff;
   localparam int MAX_PACKET   = 128;

   // image types and pixel depths
   localparam logic [7:0] TGA_TRUE     = 8'd2;
   localparam logic [7:0] TGA_GRAY     = 8'd3;
   localparam logic [7:0] TGA_TRUE_RLE = 8'd10;
   localparam logic [7:0] TGA_GRAY_RLE = 8'd11;
   localparam logic [7:0] BPP_32       = 8'd32;
   localparam logic [7:0] BPP_24       = 8'd24;
   localparam logic [7:0] BPP_8        = 8'd8;
   localparam logic [7:0] NO_COLOUR_MAP = 8'd0;

   localparam logic [7:0] RLE_RUN_FLAG = 8'd128;
   localparam logic [7:0] RLE_RUN_BIAS = 8'd127;
   localparam logic [7:0] OPAQUE       = 8'd255;

   // header byte offsets
   localparam logic [4:0] HDR_ID_LEN    = 5'd0;
   localparam logic [4:0] HDR_MAP_TYPE  = 5'd1;
   localparam logic [4:0] HDR_IMG_TYPE  = 5'd2;
   localparam logic [4:0] HDR_WIDTH_LO  = 5'd12;
   localparam logic [4:0] HDR_WIDTH_HI  = 5'd13;
   localparam logic [4:0] HDR_HEIGHT_LO = 5'd14;
   localparam logic [4:0] HDR_HEIGHT_HI = 5'd15;
   localparam logic [4:0] HDR_BPP       = 5'd16;
   localparam logic [4:0] HDR_END       = 5'd17;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_HEADER,
      ST_ID_SKIP,
      ST_PACKET_HEAD,
      ST_PIXEL,
      ST_DONE
   } decode_phase_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   logic [BYTE_W-1:0] req_data_byte = '0;
   logic req_first_byte = 1'b0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   logic [KIND_W-1:0] rsp_kind;
   logic [DIM_W-1:0] rsp_image_width;
   logic [DIM_W-1:0] rsp_image_height;
   logic [BYTE_W-1:0] rsp_red;
   logic [BYTE_W-1:0] rsp_green;
   logic [BYTE_W-1:0] rsp_blue;
   logic [BYTE_W-1:0] rsp_alpha;
   logic [RUN_W-1:0] rsp_run_length;
   logic rsp_last;

   int req_gap_pct = 23;
   int rsp_stall_pct = 81;
   int mismatch_count = 0;
   int bytes_sent = 0;
   int cycle_count = 0;

   // decoder state mirrored in the bench
   decode_phase_type phase = ST_IDLE;
   logic [4:0] hdr_index = '0;
   logic [7:0] id_left = '0;
   logic [7:0] map_type_q = '0;
   logic [7:0] image_type_q = '0;
   logic [7:0] bpp_q = '0;
   logic [15:0] width_q = '0;
   logic [15:0] height_q = '0;
   logic [31:0] pixels_left = '0;
   logic [7:0] packet_left = '0;
   logic packet_is_run = 1'b0;
   logic [1:0] colour_index = '0;
   logic [23:0] colour_bytes = '0;

   result_type decoded_results[$];
   logic [7:0] file_bytes[$];

   tga_stream_pixel_decoder dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_data_byte    (req_data_byte),
      .req_first_byte   (req_first_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_kind         (rsp_kind),
      .rsp_image_width  (rsp_image_width),
      .rsp_image_height (rsp_image_height),
      .rsp_red          (rsp_red),
      .rsp_green        (rsp_green),
      .rsp_blue         (rsp_blue),
      .rsp_alpha        (rsp_alpha),
      .rsp_run_length   (rsp_run_length),
      .rsp_last         (rsp_last)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   // ---------------------------------------------------------------- decoder

   function automatic logic is_rle_image();
      return image_type_q == TGA_TRUE_RLE || image_type_q == TGA_GRAY_RLE;
   endfunction

   function automatic decode_phase_type data_phase();
      return is_rle_image() ? ST_PACKET_HEAD : ST_PIXEL;
   endfunction

   task automatic take_header_byte(input logic [7:0] b);
      result_type r;
      logic [4:0] idx;
      logic type_ok;
      logic bpp_ok;
      idx = hdr_index;
      case (idx)
         HDR_ID_LEN:    id_left = b;
         HDR_MAP_TYPE:  map_type_q = b;
         HDR_IMG_TYPE:  image_type_q = b;
         HDR_WIDTH_LO:  width_q[7:0] = b;
         HDR_WIDTH_HI:  width_q[15:8] = b;
         HDR_HEIGHT_LO: height_q[7:0] = b;
         HDR_HEIGHT_HI: height_q[15:8] = b;
         HDR_BPP:       bpp_q = b;
         default: ;
      endcase
      hdr_index = idx + 5'd1;
      if (idx == HDR_END) begin
         type_ok = image_type_q == TGA_TRUE || image_type_q == TGA_GRAY ||
                   image_type_q == TGA_TRUE_RLE || image_type_q == TGA_GRAY_RLE;
         bpp_ok = bpp_q == BPP_32 || bpp_q == BPP_24 || bpp_q == BPP_8;
         r = '0;
         r.kind = KIND_ACCEPT;
         r.image_width = width_q;
         r.image_height = height_q;
         if (!type_ok || !bpp_ok || map_type_q != NO_COLOUR_MAP) begin
            r.kind = KIND_REJECT;
            r.last = 1'b1;
            phase = ST_DONE;
         end else begin
            // 32-bit product, operands widen to the target
            pixels_left = width_q * height_q;
            packet_left = '0;
            packet_is_run = 1'b0;
            colour_index = '0;
            colour_bytes = '0;
            if (pixels_left == 0) begin
               r.last = 1'b1;
               phase = ST_DONE;
            end else if (id_left != 0) begin
               phase = ST_ID_SKIP;
            end else begin
               phase = data_phase();
            end
         end
         decoded_results.push_back(r);
      end
   endtask

   task automatic take_pixel_byte(input logic [7:0] b);
      result_type r;
      logic [7:0] red_v;
      logic [7:0] green_v;
      logic [7:0] blue_v;
      logic [7:0] alpha_v;
      logic [31:0] run;
      logic complete;
      int nbytes;
      complete = 1'b1;
      if (image_type_q == TGA_GRAY || image_type_q == TGA_GRAY_RLE) begin
         red_v = b;
         green_v = b;
         blue_v = b;
         alpha_v = OPAQUE;
      end else begin
         nbytes = (bpp_q == BPP_32) ? 4 : 3;
         if (colour_index < 2'd3)
            colour_bytes = colour_bytes | ({16'd0, b} << (8 * colour_index));
         if (colour_index + 1 < nbytes) begin
            colour_index = colour_index + 2'd1;
            complete = 1'b0;
         end else begin
            blue_v = colour_bytes[7:0];
            green_v = colour_bytes[15:8];
            red_v = colour_bytes[23:16];
            alpha_v = (nbytes == 4) ? b : OPAQUE;
            colour_index = '0;
            colour_bytes = '0;
         end
      end
      if (complete) begin
         run = 1;
         if (is_rle_image() && packet_is_run) begin
            // a run never covers more than what is left of the image
            run = (packet_left > pixels_left) ? pixels_left : packet_left;
            packet_left = '0;
         end else if (is_rle_image()) begin
            packet_left = packet_left - 8'd1;
         end
         pixels_left = pixels_left - run;
         r = '0;
         r.kind = KIND_RUN;
         r.red = red_v;
         r.green = green_v;
         r.blue = blue_v;
         r.alpha = alpha_v;
         r.run_length = run[7:0];
         if (pixels_left == 0) begin
            r.last = 1'b1;
            phase = ST_DONE;
         end else if (is_rle_image() && packet_left == 0) begin
            phase = ST_PACKET_HEAD;
         end else begin
            phase = ST_PIXEL;
         end
         decoded_results.push_back(r);
      end
   endtask

   task automatic decode_byte(input logic [7:0] b, input logic first);
      if (first) begin
         phase = ST_HEADER;
         hdr_index = '0;
         take_header_byte(b);
      end else begin
         case (phase)
            ST_HEADER: take_header_byte(b);
            ST_ID_SKIP: begin
               id_left = id_left - 8'd1;
               if (id_left == 0)
                  phase = data_phase();
            end
            ST_PACKET_HEAD: begin
               if (b < RLE_RUN_FLAG) begin
                  packet_is_run = 1'b0;
                  packet_left = b + 8'd1;
               end else begin
                  packet_is_run = 1'b1;
                  packet_left = b - RLE_RUN_BIAS;
               end
               colour_index = '0;
               colour_bytes = '0;
               phase = ST_PIXEL;
            end
            ST_PIXEL: take_pixel_byte(b);
            default: ;
         endcase
      end
   endtask

   // ---------------------------------------------------------------- transfers

   task automatic send_byte(input logic [7:0] b, input logic first);
      while ($urandom_range(99) < req_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data_byte <= b;
      req_first_byte <= first;
      do @(posedge clock); while (req_ready !== 1'b1);
      decode_byte(b, first);
      bytes_sent++;
   endtask

   task automatic send_file(input int keep_count);
      int i;
      for (i = 0; i < file_bytes.size() && i < keep_count; i++)
         send_byte(file_bytes[i], i == 0);
      file_bytes.delete();
   endtask

   task automatic compare_field(input string name, input logic [15:0] want,
                                input logic [15:0] got);
      if (got !== want) begin
         mismatch_count++;
         $display("%0t: %s mismatch, expected %0h, actual %0h",
                  $time, name, want, got);
      end
   endtask

   always @(posedge clock) begin
      result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (decoded_results.size() == 0) begin
            mismatch_count++;
            $display("%0t: result transfer, expected none, actual kind %0h",
                     $time, rsp_kind);
         end else begin
            want = decoded_results.pop_front();
            compare_field("kind", want.kind, rsp_kind);
            compare_field("image_width", want.image_width, rsp_image_width);
            compare_field("image_height", want.image_height, rsp_image_height);
            compare_field("red", want.red, rsp_red);
            compare_field("green", want.green, rsp_green);
            compare_field("blue", want.blue, rsp_blue);
            compare_field("alpha", want.alpha, rsp_alpha);
            compare_field("run_length", want.run_length, rsp_run_length);
            compare_field("last", want.last, rsp_last);
         end
      end
      rsp_ready <= ($urandom_range(99) >= rsp_stall_pct);
   end

   // ---------------------------------------------------------------- file builders

   task automatic build_header(input logic [7:0] id_len, input logic [7:0] cmap,
                               input logic [7:0] itype, input logic [15:0] w,
                               input logic [15:0] h, input logic [7:0] bpp);
      int i;
      file_bytes.push_back(id_len);
      file_bytes.push_back(cmap);
      file_bytes.push_back(itype);
      // colour map spec and origin are don't-care
      for (i = HDR_IMG_TYPE + 1; i < HDR_WIDTH_LO; i++)
         file_bytes.push_back(8'($urandom_range(255)));
      file_bytes.push_back(w[7:0]);
      file_bytes.push_back(w[15:8]);
      file_bytes.push_back(h[7:0]);
      file_bytes.push_back(h[15:8]);
      file_bytes.push_back(bpp);
      file_bytes.push_back(8'($urandom_range(255)));
   endtask

   task automatic push_pixels(input logic [7:0] itype, input logic [7:0] bpp,
                              input int count);
      int i;
      int per_pixel;
      if (itype == TGA_GRAY || itype == TGA_GRAY_RLE)
         per_pixel = 1;
      else
         per_pixel = (bpp == BPP_32) ? 4 : 3;
      for (i = 0; i < count * per_pixel; i++)
         file_bytes.push_back(8'($urandom_range(255)));
   endtask

   task automatic build_image(input logic [7:0] itype, input logic [7:0] bpp,
                              input logic [7:0] id_len, input logic [15:0] w,
                              input logic [15:0] h);
      int i;
      int remaining;
      int count;
      build_header(id_len, NO_COLOUR_MAP, itype, w, h, bpp);
      for (i = 0; i < id_len; i++)
         file_bytes.push_back(8'($urandom_range(255)));
      remaining = w * h;
      if (itype == TGA_TRUE_RLE || itype == TGA_GRAY_RLE) begin
         while (remaining > 0) begin
            if ($urandom_range(1)) begin
               count = ($urandom_range(3) == 0) ? $urandom_range(1, MAX_PACKET)
                                                : $urandom_range(1, 4);
               file_bytes.push_back(8'(RLE_RUN_BIAS + count));
               push_pixels(itype, bpp, 1);
            end else begin
               count = $urandom_range(1, 4);
               file_bytes.push_back(8'(count - 1));
               push_pixels(itype, bpp, count);
            end
            remaining -= (count < remaining) ? count : remaining;
         end
      end else begin
         push_pixels(itype, bpp, remaining);
      end
   endtask

   function automatic logic [7:0] any_good_type();
      case ($urandom_range(3))
         0: return TGA_TRUE;
         1: return TGA_GRAY;
         2: return TGA_TRUE_RLE;
         default: return TGA_GRAY_RLE;
      endcase
   endfunction

   function automatic logic [7:0] any_good_bpp();
      case ($urandom_range(2))
         0: return BPP_32;
         1: return BPP_24;
         default: return BPP_8;
      endcase
   endfunction

   // ---------------------------------------------------------------- tests

   task automatic test_stray_bytes();
      // nothing has started a file yet
      send_byte(8'h00, 1'b0);
      send_byte(8'hff, 1'b0);
      send_byte(8'h5a, 1'b0);
   endtask

   task automatic test_header_checks();
      build_header(8'd0, NO_COLOUR_MAP, 8'd0, 16'd3, 16'd2, BPP_24);
      send_file(WHOLE_FILE);
      build_header(8'd0, NO_COLOUR_MAP, 8'hff, 16'hffff, 16'hffff, BPP_8);
      send_file(WHOLE_FILE);
      build_header(8'd0, 8'd1, TGA_TRUE, 16'd4, 16'd4, BPP_24);
      send_file(WHOLE_FILE);
      build_header(8'hff, 8'hff, TGA_GRAY_RLE, 16'd4, 16'd4, BPP_8);
      send_file(WHOLE_FILE);
      build_header(8'd0, NO_COLOUR_MAP, TGA_TRUE_RLE, 16'd4, 16'd4, 8'd16);
      send_file(WHOLE_FILE);
      build_header(8'd0, NO_COLOUR_MAP, TGA_GRAY, 16'd4, 16'd4, 8'hff);
      send_file(WHOLE_FILE);
      build_header(8'd0, NO_COLOUR_MAP, TGA_TRUE, 16'd4, 16'd4, 8'd0);
      send_file(WHOLE_FILE);
      // empty images finish on the header
      build_header(8'd5, NO_COLOUR_MAP, TGA_TRUE, 16'd0, 16'hffff, BPP_32);
      send_file(WHOLE_FILE);
      build_header(8'd0, NO_COLOUR_MAP, TGA_GRAY_RLE, 16'hffff, 16'd0, BPP_8);
      send_file(WHOLE_FILE);
   endtask

   task automatic test_raw_colour();
      build_header(8'd0, NO_COLOUR_MAP, TGA_TRUE, 16'd1, 16'd2, BPP_32);
      repeat (4) file_bytes.push_back(8'h00);
      repeat (4) file_bytes.push_back(8'hff);
      send_file(WHOLE_FILE);
      build_image(TGA_TRUE, BPP_24, 8'd0, 16'd2, 16'd1);
      send_file(WHOLE_FILE);
      // 8 bpp true colour still reads three bytes
      build_image(TGA_TRUE, BPP_8, 8'd0, 16'd2, 16'd1);
      send_file(WHOLE_FILE);
   endtask

   task automatic test_gray();
      build_image(TGA_GRAY, BPP_8, 8'd0, 16'd3, 16'd1);
      send_file(WHOLE_FILE);
      build_image(TGA_GRAY, BPP_32, 8'd0, 16'd2, 16'd2);
      send_file(WHOLE_FILE);
      build_image(TGA_GRAY, BPP_24, 8'd0, 16'd1, 16'd1);
      send_file(WHOLE_FILE);
   endtask

   task automatic test_rle_packets();
      // longest run exactly fills the image
      build_header(8'd0, NO_COLOUR_MAP, TGA_GRAY_RLE, 16'd16, 16'd8, BPP_8);
      file_bytes.push_back(8'hff);
      push_pixels(TGA_GRAY_RLE, BPP_8, 1);
      send_file(WHOLE_FILE);
      // run longer than what is left gets clamped
      build_header(8'd0, NO_COLOUR_MAP, TGA_TRUE_RLE, 16'd1, 16'd2, BPP_24);
      file_bytes.push_back(8'hff);
      push_pixels(TGA_TRUE_RLE, BPP_24, 1);
      send_file(WHOLE_FILE);
      // raw packet past the end, surplus bytes dropped
      build_header(8'd0, NO_COLOUR_MAP, TGA_GRAY_RLE, 16'd1, 16'd1, BPP_32);
      file_bytes.push_back(8'h05);
      push_pixels(TGA_GRAY_RLE, BPP_32, 6);
      send_file(WHOLE_FILE);
      build_header(8'd0, NO_COLOUR_MAP, TGA_TRUE_RLE, 16'd2, 16'd1, BPP_32);
      file_bytes.push_back(8'h00);
      push_pixels(TGA_TRUE_RLE, BPP_32, 1);
      file_bytes.push_back(RLE_RUN_FLAG);
      push_pixels(TGA_TRUE_RLE, BPP_32, 1);
      send_file(WHOLE_FILE);
      build_image(TGA_TRUE_RLE, BPP_8, 8'd0, 16'd4, 16'd3);
      send_file(WHOLE_FILE);
      build_image(TGA_GRAY_RLE, BPP_24, 8'd0, 16'd5, 16'd2);
      send_file(WHOLE_FILE);
   endtask

   task automatic test_id_field();
      build_image(TGA_TRUE, BPP_24, 8'd12, 16'd1, 16'd1);
      send_file(WHOLE_FILE);
      build_image(TGA_GRAY_RLE, BPP_8, 8'd1, 16'd2, 16'd1);
      send_file(WHOLE_FILE);
   endtask

   task automatic test_restart();
      // abandoned inside the header
      build_image(TGA_TRUE, BPP_32, 8'd0, 16'd2, 16'd2);
      send_file(9);
      // abandoned inside the pixel data unless one run packet covers the image
      build_image(TGA_TRUE_RLE, BPP_24, 8'd2, 16'd3, 16'd3);
      send_file(25);
      build_image(TGA_GRAY, BPP_8, 8'd0, 16'd2, 16'd1);
      send_file(WHOLE_FILE);
   endtask

   task automatic test_after_end();
      build_image(TGA_GRAY, BPP_8, 8'd0, 16'd1, 16'd1);
      push_pixels(TGA_GRAY, BPP_8, 3);
      send_file(WHOLE_FILE);
      build_header(8'd0, 8'd1, TGA_TRUE, 16'd2, 16'd2, BPP_24);
      push_pixels(TGA_TRUE, BPP_24, 2);
      send_file(WHOLE_FILE);
   endtask

   task automatic test_random_files(input int item_goal);
      int stop_at;
      int pick;
      int i;
      logic [7:0] itype;
      logic [7:0] bpp;
      logic [7:0] cmap;
      logic [7:0] id_len;
      logic [15:0] w;
      logic [15:0] h;
      stop_at = bytes_sent + item_goal;
      while (bytes_sent < stop_at) begin
         pick = $urandom_range(99);
         itype = any_good_type();
         bpp = any_good_bpp();
         cmap = NO_COLOUR_MAP;
         id_len = ($urandom_range(3) == 0) ? 8'($urandom_range(1, 6)) : 8'd0;
         w = 16'($urandom_range(1, 5));
         h = 16'($urandom_range(1, 4));
         if (pick < 65) begin
            build_image(itype, bpp, id_len, w, h);
            if ($urandom_range(4) == 0)
               push_pixels(TGA_GRAY, bpp, $urandom_range(1, 3));
            // a few files are cut short and abandoned by the next one
            send_file((pick < 10) ? $urandom_range(1, file_bytes.size()) : WHOLE_FILE);
         end else if (pick < 75) begin
            w = 16'($urandom_range(16'hffff));
            h = 16'($urandom_range(16'hffff));
            if ($urandom_range(1))
               w = '0;
            else
               h = '0;
            build_header(id_len, cmap, itype, w, h, bpp);
            send_file(WHOLE_FILE);
         end else if (pick < 90) begin
            w = 16'($urandom_range(16'hffff));
            h = 16'($urandom_range(16'hffff));
            case ($urandom_range(3))
               0: itype = 8'($urandom_range(255));
               1: bpp = 8'($urandom_range(255));
               2: cmap = 8'($urandom_range(1, 255));
               default: begin
                  itype = 8'($urandom_range(255));
                  bpp = 8'($urandom_range(255));
                  cmap = 8'($urandom_range(255));
               end
            endcase
            build_header(id_len, cmap, itype, w, h, bpp);
            push_pixels(TGA_GRAY, bpp, $urandom_range(0, 3));
            send_file(WHOLE_FILE);
         end else begin
            for (i = 0; i < $urandom_range(1, 6); i++)
               send_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
         end
      end
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_stray_bytes();
      test_header_checks();
      test_raw_colour();
      test_gray();
      test_rle_packets();
      test_id_field();
      test_restart();
      test_after_end();
      test_random_files(30);
      req_gap_pct = 81;
      rsp_stall_pct = 23;
      test_random_files(30);
      req_gap_pct = 0;
      rsp_stall_pct = 0;
      test_random_files(30);
      req_valid <= 1'b0;
      while (decoded_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
